// ===== sv/qpp_pkg.sv =====
package qpp_pkg;

  localparam int unsigned CountsPerTurnDef = 216;
  localparam int unsigned PwmRangeDef      = 100;

  localparam int GainW   = 18;
  localparam int TargetW = 4;
  localparam int PosW    = 24;
  localparam int ErrW    = 24;
  localparam int CtrlW   = 32;
  localparam int DutyW   = 7;
  localparam int FracW   = 12;
  localparam int AccW    = CtrlW + FracW;
  localparam int CfgIdxW = 2;

  typedef logic signed [GainW-1:0]   gain_t;
  typedef logic signed [TargetW-1:0] target_t;
  typedef logic signed [PosW-1:0]    pos_t;
  typedef logic signed [ErrW-1:0]    err_t;
  typedef logic signed [CtrlW-1:0]   ctrl_t;
  typedef logic signed [AccW-1:0]    acc_t;
  typedef logic [DutyW-1:0]          duty_t;

  localparam gain_t GainNowRst   = 18'sd1915;
  localparam gain_t GainPrevRst  = -18'sd3812;
  localparam gain_t GainPrev2Rst = 18'sd1896;

  typedef enum logic [1:0] {
    OP_EDGE_A = 2'd0,
    OP_EDGE_B = 2'd1,
    OP_TICK   = 2'd2
  } op_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_GAIN_NOW   = 2'd0,
    CFG_GAIN_PREV  = 2'd1,
    CFG_GAIN_PREV2 = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    op_e     opcode;
    logic    level_a;
    logic    level_b;
    target_t target_turns;
  } item_t;

  typedef struct packed {
    pos_t  position_counts;
    err_t  error_counts;
    ctrl_t control_value;
    duty_t drive_one;
    duty_t drive_two;
  } result_t;

  typedef struct packed {
    cfg_idx_e index;
    gain_t    wdata;
  } cfg_t;

  // Outcome of one control tick, handed from the PID datapath to the state registers.
  typedef struct packed {
    err_t  err;
    acc_t  acc;
    duty_t duty_one;
    duty_t duty_two;
  } pid_res_t;

  // Integer part of a Q32.12 accumulator, rounded toward zero.
  function automatic ctrl_t acc_int(input acc_t a);
    acc_t biased;
    biased = a[AccW-1] ? a + acc_t'((1 << FracW) - 1) : a;
    return biased[AccW-1 -: CtrlW];
  endfunction

endpackage

// ===== sv/qpp_stream_if.sv =====
interface qpp_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// ===== sv/qpp_enc_count.sv =====
module qpp_enc_count (
  input  qpp_pkg::op_e  opcode_i,
  input  logic          level_a_i,
  input  logic          level_b_i,
  input  qpp_pkg::pos_t position_i,
  output qpp_pkg::pos_t position_o
);
  import qpp_pkg::*;

  logic count_up;
  logic count_en;

  always_comb begin
    count_up = 1'b0;
    count_en = 1'b0;
    unique case (opcode_i)
      OP_EDGE_A: begin
        count_en = 1'b1;
        count_up = level_a_i ^ level_b_i;
      end
      OP_EDGE_B: begin
        count_en = 1'b1;
        count_up = ~(level_a_i ^ level_b_i);
      end
      default: begin
        count_en = 1'b0;
      end
    endcase
  end

  always_comb begin
    if (!count_en) begin
      position_o = position_i;
    end else if (count_up) begin
      position_o = position_i + pos_t'(1);
    end else begin
      position_o = position_i - pos_t'(1);
    end
  end

endmodule

// ===== sv/qpp_pid_core.sv =====
module qpp_pid_core #(
  parameter int unsigned COUNTS_PER_TURN = qpp_pkg::CountsPerTurnDef,
  parameter int unsigned PWM_RANGE       = qpp_pkg::PwmRangeDef
) (
  input  qpp_pkg::target_t  target_i,
  input  qpp_pkg::pos_t     position_i,
  input  qpp_pkg::acc_t     acc_i,
  input  qpp_pkg::err_t     err_last_i,
  input  qpp_pkg::err_t     err_before_i,
  input  qpp_pkg::gain_t    gain_now_i,
  input  qpp_pkg::gain_t    gain_prev_i,
  input  qpp_pkg::gain_t    gain_prev2_i,
  output qpp_pkg::pid_res_t res_o
);
  import qpp_pkg::*;

  localparam int CptW  = $clog2(COUNTS_PER_TURN + 1) + 1;
  localparam int RefW  = CptW + TargetW;
  localparam int RawW  = ((RefW > PosW) ? RefW : PosW) + 1;
  localparam int MulW  = GainW + ErrW;
  localparam int SumW  = AccW + 2;
  localparam logic signed [CptW-1:0] CptS  = CptW'(COUNTS_PER_TURN);
  localparam ctrl_t                  PwmS  = CtrlW'(PWM_RANGE);
  localparam duty_t                  PwmD  = DutyW'(PWM_RANGE);

  logic signed [RefW-1:0] ref_counts;
  logic signed [RawW-1:0] err_raw;
  err_t                   err;
  logic signed [MulW-1:0] p_now, p_prev, p_prev2;
  logic signed [SumW-1:0] sum;
  acc_t                   acc_new;
  ctrl_t                  cv;
  ctrl_t                  cv_neg;
  logic                   err_pos;

  assign ref_counts = target_i * CptS;
  assign err_raw    = RawW'(ref_counts) - RawW'(position_i);

  // Saturate the error when the bits above the sign do not all agree.
  always_comb begin
    if ((&err_raw[RawW-1:ErrW-1]) || !(|err_raw[RawW-1:ErrW-1])) begin
      err = err_raw[ErrW-1:0];
    end else begin
      err = {err_raw[RawW-1], {(ErrW-1){~err_raw[RawW-1]}}};
    end
  end

  assign p_now   = gain_now_i * err;
  assign p_prev  = gain_prev_i * err_last_i;
  assign p_prev2 = gain_prev2_i * err_before_i;

  assign sum = SumW'(acc_i) + SumW'(p_now) + SumW'(p_prev) + SumW'(p_prev2);

  always_comb begin
    if ((&sum[SumW-1:AccW-1]) || !(|sum[SumW-1:AccW-1])) begin
      acc_new = sum[AccW-1:0];
    end else begin
      acc_new = {sum[SumW-1], {(AccW-1){~sum[SumW-1]}}};
    end
  end

  assign cv      = acc_int(acc_new);
  assign cv_neg  = -cv;
  assign err_pos = !err[ErrW-1] && (err != '0);

  always_comb begin
    res_o.err      = err;
    res_o.acc      = acc_new;
    res_o.duty_one = '0;
    res_o.duty_two = '0;
    if (err_pos) begin
      if (cv < -PwmS) begin
        res_o.duty_one = PwmD;
      end else if (cv < 0) begin
        res_o.duty_one = cv_neg[DutyW-1:0];
      end
    end else begin
      if (cv > PwmS) begin
        res_o.duty_two = PwmD;
      end else if (cv > 0) begin
        res_o.duty_two = cv[DutyW-1:0];
      end
    end
  end

endmodule

// ===== sv/quadrature_position_pid.sv =====
// Channel   Dir  Payload                                           Handshake
// item_i    in   opcode, level_a, level_b, target_turns            valid/ready
// result_o  out  position_counts, error_counts, control_value,     valid/ready
//                drive_one, drive_two
// cfg_i     in   index (gain_now, gain_prev, gain_prev2), wdata    valid/ready
//
// One item per cycle while result_o is ready; a result is registered after its
// beat is taken (input register, then one pass through the encoder counter and
// the PID datapath into the result register). rst_ni clears all servo state and
// loads the default gains. A stalled result holds the result register; the input
// register still takes a beat whenever the result register is moving or empty.
module quadrature_position_pid #(
  parameter int unsigned COUNTS_PER_TURN = qpp_pkg::CountsPerTurnDef,
  parameter int unsigned PWM_RANGE       = qpp_pkg::PwmRangeDef
) (
  input logic         clk_i,
  input logic         rst_ni,
  qpp_stream_if.sink   item_i,
  qpp_stream_if.source result_o,
  qpp_stream_if.sink   cfg_i
);
  import qpp_pkg::*;

  logic     in_valid_q;
  item_t    in_q;
  logic     out_valid_q;
  result_t  result_q;
  logic     advance;

  gain_t    gain_now_q, gain_prev_q, gain_prev2_q;
  pos_t     position_q, position_d, position_edge;
  err_t     err_last_q, err_last_d, err_before_q, err_before_d;
  acc_t     acc_q, acc_d;
  duty_t    duty_one_q, duty_one_d, duty_two_q, duty_two_d;
  pid_res_t pid_res;
  result_t  result_d;

  assign advance      = in_valid_q && (!out_valid_q || result_o.ready);
  assign item_i.ready = !in_valid_q || advance;
  assign cfg_i.ready  = 1'b1;

  assign result_o.valid   = out_valid_q;
  assign result_o.payload = result_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (item_i.valid && item_i.ready) begin
        in_valid_q <= 1'b1;
      end else if (advance) begin
        in_valid_q <= 1'b0;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (result_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (item_i.valid && item_i.ready) begin
      in_q <= item_i.payload;
    end
    if (advance) begin
      result_q <= result_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_now_q   <= GainNowRst;
      gain_prev_q  <= GainPrevRst;
      gain_prev2_q <= GainPrev2Rst;
    end else if (cfg_i.valid && cfg_i.ready) begin
      unique case (cfg_i.payload.index)
        CFG_GAIN_NOW:   gain_now_q   <= cfg_i.payload.wdata;
        CFG_GAIN_PREV:  gain_prev_q  <= cfg_i.payload.wdata;
        CFG_GAIN_PREV2: gain_prev2_q <= cfg_i.payload.wdata;
        default: begin
        end
      endcase
    end
  end

  qpp_enc_count u_enc_count (
    .opcode_i   (in_q.opcode),
    .level_a_i  (in_q.level_a),
    .level_b_i  (in_q.level_b),
    .position_i (position_q),
    .position_o (position_edge)
  );

  qpp_pid_core #(
    .COUNTS_PER_TURN (COUNTS_PER_TURN),
    .PWM_RANGE       (PWM_RANGE)
  ) u_pid_core (
    .target_i     (in_q.target_turns),
    .position_i   (position_q),
    .acc_i        (acc_q),
    .err_last_i   (err_last_q),
    .err_before_i (err_before_q),
    .gain_now_i   (gain_now_q),
    .gain_prev_i  (gain_prev_q),
    .gain_prev2_i (gain_prev2_q),
    .res_o        (pid_res)
  );

  // The last error reported is always the newest one kept for the PID history.
  always_comb begin
    position_d   = position_edge;
    err_last_d   = err_last_q;
    err_before_d = err_before_q;
    acc_d        = acc_q;
    duty_one_d   = duty_one_q;
    duty_two_d   = duty_two_q;
    if (in_q.opcode == OP_TICK) begin
      err_last_d   = pid_res.err;
      err_before_d = err_last_q;
      acc_d        = pid_res.acc;
      duty_one_d   = pid_res.duty_one;
      duty_two_d   = pid_res.duty_two;
    end
  end

  always_comb begin
    result_d.position_counts = position_d;
    result_d.error_counts    = err_last_d;
    result_d.control_value   = acc_int(acc_d);
    result_d.drive_one       = duty_one_d;
    result_d.drive_two       = duty_two_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      position_q   <= '0;
      err_last_q   <= '0;
      err_before_q <= '0;
      acc_q        <= '0;
      duty_one_q   <= '0;
      duty_two_q   <= '0;
    end else if (advance) begin
      position_q   <= position_d;
      err_last_q   <= err_last_d;
      err_before_q <= err_before_d;
      acc_q        <= acc_d;
      duty_one_q   <= duty_one_d;
      duty_two_q   <= duty_two_d;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !((duty_one_q != '0) && (duty_two_q != '0)))
    else $error("both motor inputs driven at once");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && (in_q.opcode != OP_TICK)) |=> $stable(acc_q) && $stable(err_last_q))
    else $error("controller state changed on a non-tick item");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> out_valid_q)
    else $error("processed item produced no result");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ##1 ((position_q == $past(position_q)) ||
         (pos_t'(position_q - $past(position_q)) == pos_t'(1)) ||
         (pos_t'($past(position_q) - position_q) == pos_t'(1))))
    else $error("encoder count moved by more than one step");

endmodule
